>>> rtl/ssku_pkg.sv
// shared constants, types and helper functions for the steady-state kalman update block
// memory layout of the vector store, item codes, rounding and count clamping
// no dependencies
package ssku_pkg;

    localparam int MAX_STATES       = 8;
    localparam int MAX_CONTROLS     = 4;
    localparam int MAX_MEASUREMENTS = 4;
    localparam int FRACTION_BITS    = 16;
    localparam int DIM              = 8;

    localparam int CAP_STATES       = (MAX_STATES < DIM) ? MAX_STATES : DIM;
    localparam int CAP_CONTROLS     = (MAX_CONTROLS < DIM) ? MAX_CONTROLS : DIM;
    localparam int CAP_MEASUREMENTS = (MAX_MEASUREMENTS < DIM) ? MAX_MEASUREMENTS : DIM;

    localparam int IDX_W      = $clog2(DIM);
    localparam int VALUE_W    = 32;
    localparam int OPND_W     = VALUE_W + 1;
    localparam int PROD_W     = VALUE_W + OPND_W;
    localparam int ACC_W      = PROD_W + 5;
    localparam int SUM_W      = ACC_W + 1;
    localparam int SH_W       = SUM_W - FRACTION_BITS;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int COEF_DEPTH = 256;
    localparam int CADDR_W    = $clog2(COEF_DEPTH);

    // vector store: x, u, y (reset to zero), innovation and next state (scratch)
    localparam int X_BASE    = 0;
    localparam int U_BASE    = X_BASE + MAX_STATES;
    localparam int Y_BASE    = U_BASE + MAX_CONTROLS;
    localparam int E_BASE    = Y_BASE + MAX_MEASUREMENTS;
    localparam int N_BASE    = E_BASE + MAX_MEASUREMENTS;
    localparam int VEC_DEPTH = N_BASE + MAX_STATES;
    localparam int VADDR_W   = $clog2(VEC_DEPTH);
    localparam int VLD_W     = $clog2(E_BASE);

    typedef enum logic [2:0] {
        FUNC_COEF    = 3'd0,
        FUNC_CONTROL = 3'd1,
        FUNC_MEAS    = 3'd2,
        FUNC_STEP    = 3'd3,
        FUNC_PRESET  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        MAT_A = 2'd0,
        MAT_B = 2'd1,
        MAT_C = 2'd2,
        MAT_K = 2'd3
    } t_matrix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_COUNT   = 2'd0,
        CFG_CONTROL_COUNT = 2'd1,
        CFG_MEAS_COUNT    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic               we;
        logic [CADDR_W-1:0] addr;
        logic [VALUE_W-1:0] data;
    } t_coef_wr;

    typedef struct packed {
        logic               we;
        logic [VADDR_W-1:0] addr;
        logic [OPND_W-1:0]  data;
    } t_vec_wr;

    typedef struct packed {
        logic issue;
        logic clear;
    } t_mac_ctl;

    // clamp a count to 1..cap and return the index of the last element
    function automatic logic [IDX_W-1:0] last_index(logic [3:0] cnt, int cap);
        logic [3:0] c;
        if (cnt == 4'd0) begin
            c = 4'd1;
        end else if (cnt > cap) begin
            c = 4'(cap);
        end else begin
            c = cnt;
        end
        return IDX_W'(c - 4'd1);
    endfunction

    // round half up at the binary point, then saturate to 32 bits
    function automatic logic [VALUE_W-1:0] round_sat(logic [ACC_W-1:0] a);
        logic [SUM_W-1:0]       s;
        logic [SH_W-1:0]        sh;
        logic [SH_W-VALUE_W:0]  hi;
        s  = {a[ACC_W-1], a} + (SUM_W'(1) << (FRACTION_BITS - 1));
        sh = s[SUM_W-1:FRACTION_BITS];
        hi = sh[SH_W-1:VALUE_W-1];
        if (hi == '0 || hi == '1) begin
            return sh[VALUE_W-1:0];
        end else if (sh[SH_W-1]) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> rtl/ssku_coef_mem.sv
// coefficient store for matrices a, b, c and k, one synchronous read port
// per-entry valid bits make unwritten entries read as zero after reset; uses ssku_pkg
module ssku_coef_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssku_pkg::t_coef_wr                  i_wr,
    input  logic [ssku_pkg::CADDR_W-1:0]        i_raddr,
    output logic [ssku_pkg::VALUE_W-1:0]        o_rdata
);

    logic [ssku_pkg::VALUE_W-1:0]    r_mem [ssku_pkg::COEF_DEPTH];
    logic [ssku_pkg::COEF_DEPTH-1:0] r_valid;
    logic [ssku_pkg::VALUE_W-1:0]    r_q;
    logic                            r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_qv <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

>>> rtl/ssku_vec_mem.sv
// vector store: state, control, measurement, innovation and next-state entries
// one write and one synchronous read port; x, u and y read as zero until written; uses ssku_pkg
module ssku_vec_mem (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssku_pkg::t_vec_wr                   i_wr,
    input  logic [ssku_pkg::VADDR_W-1:0]        i_raddr,
    output logic [ssku_pkg::OPND_W-1:0]         o_rdata
);

    logic [ssku_pkg::OPND_W-1:0] r_mem [ssku_pkg::VEC_DEPTH];
    logic [ssku_pkg::E_BASE-1:0] r_valid;
    logic [ssku_pkg::OPND_W-1:0] r_q;
    logic                        r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr.we && i_wr.addr < ssku_pkg::E_BASE) begin
                r_valid[i_wr.addr[ssku_pkg::VLD_W-1:0]] <= 1'b1;
            end
            if (i_raddr < ssku_pkg::E_BASE) begin
                r_qv <= r_valid[i_raddr[ssku_pkg::VLD_W-1:0]];
            end else begin
                r_qv <= 1'b1;
            end
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

>>> rtl/ssku_mac.sv
// multiply-accumulate unit: registered product, wide accumulator, rounded result
// product register after the multiplier, rounding register after the accumulator; uses ssku_pkg
module ssku_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssku_pkg::t_mac_ctl                  i_ctl,
    input  logic [ssku_pkg::VALUE_W-1:0]        i_coef,
    input  logic [ssku_pkg::OPND_W-1:0]         i_opnd,
    output logic                                o_busy,
    output logic [ssku_pkg::VALUE_W-1:0]        o_result
);

    logic                          r_p1;
    logic                          r_p2;
    logic [ssku_pkg::PROD_W-1:0]   r_prod;
    logic [ssku_pkg::ACC_W-1:0]    r_acc;
    logic [ssku_pkg::VALUE_W-1:0]  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= i_ctl.issue;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_prod <= $signed(i_coef) * $signed(i_opnd);
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + {{(ssku_pkg::ACC_W-ssku_pkg::PROD_W){r_prod[ssku_pkg::PROD_W-1]}},
                              r_prod};
        end
        r_res <= ssku_pkg::round_sat(r_acc);
    end

    assign o_busy   = r_p1 | r_p2;
    assign o_result = r_res;

endmodule

>>> rtl/ssku_seq.sv
// step sequencer: walks the rows of c*x and a*x + b*u + k*e, writes back, emits items
// drives both store read ports, the mac unit and the output register; uses ssku_pkg
module ssku_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [3:0]                          i_state_count,
    input  logic [2:0]                          i_control_count,
    input  logic [2:0]                          i_meas_count,
    input  logic [ssku_pkg::OPND_W-1:0]         i_vec_rdata,
    input  logic                                i_mac_busy,
    input  logic [ssku_pkg::VALUE_W-1:0]        i_mac_result,
    input  logic                                i_out_ready,
    output logic                                o_idle,
    output logic [ssku_pkg::CADDR_W-1:0]        o_coef_raddr,
    output logic [ssku_pkg::VADDR_W-1:0]        o_vec_raddr,
    output ssku_pkg::t_vec_wr                   o_vec_wr,
    output ssku_pkg::t_mac_ctl                  o_mac_ctl,
    output logic                                o_out_valid,
    output logic [ssku_pkg::IDX_W-1:0]          o_state_index,
    output logic [ssku_pkg::VALUE_W-1:0]        o_state_value,
    output logic                                o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_UPDATE,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    typedef enum logic [1:0] {
        SEG_X,
        SEG_U,
        SEG_E
    } t_seg;

    t_state                        r_state;
    t_seg                          r_seg;
    logic                          r_phase_a;
    logic [ssku_pkg::IDX_W-1:0]    r_row;
    logic [ssku_pkg::IDX_W-1:0]    r_col;
    logic [ssku_pkg::IDX_W-1:0]    r_nl;
    logic [ssku_pkg::IDX_W-1:0]    r_pl;
    logic [ssku_pkg::IDX_W-1:0]    r_ml;
    logic                          r_out_valid;
    logic [ssku_pkg::IDX_W-1:0]    r_out_index;
    logic [ssku_pkg::VALUE_W-1:0]  r_out_value;
    logic                          r_out_last;

    ssku_pkg::t_matrix             sel;
    logic [ssku_pkg::VADDR_W-1:0]  mac_vaddr;
    logic [ssku_pkg::OPND_W-1:0]   res_ext;
    logic                          row_end;
    logic                          slot_free;

    always_comb begin
        if (!r_phase_a) begin
            sel       = ssku_pkg::MAT_C;
            mac_vaddr = ssku_pkg::VADDR_W'(ssku_pkg::X_BASE) + ssku_pkg::VADDR_W'(r_col);
        end else begin
            unique case (r_seg)
                SEG_X: begin
                    sel       = ssku_pkg::MAT_A;
                    mac_vaddr = ssku_pkg::VADDR_W'(ssku_pkg::X_BASE)
                              + ssku_pkg::VADDR_W'(r_col);
                end
                SEG_U: begin
                    sel       = ssku_pkg::MAT_B;
                    mac_vaddr = ssku_pkg::VADDR_W'(ssku_pkg::U_BASE)
                              + ssku_pkg::VADDR_W'(r_col);
                end
                default: begin
                    sel       = ssku_pkg::MAT_K;
                    mac_vaddr = ssku_pkg::VADDR_W'(ssku_pkg::E_BASE)
                              + ssku_pkg::VADDR_W'(r_col);
                end
            endcase
        end
    end

    assign o_coef_raddr = {sel, r_row, r_col};
    assign res_ext      = {i_mac_result[ssku_pkg::VALUE_W-1], i_mac_result};
    assign row_end      = r_phase_a ? (r_row == r_nl) : (r_row == r_ml);
    assign slot_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_vec_wr = '0;
        unique case (r_state)
            S_MAC: begin
                o_vec_raddr = mac_vaddr;
            end
            S_ROUND: begin
                o_vec_raddr = ssku_pkg::VADDR_W'(ssku_pkg::Y_BASE) + ssku_pkg::VADDR_W'(r_row);
            end
            S_EMIT_RD: begin
                o_vec_raddr = ssku_pkg::VADDR_W'(ssku_pkg::N_BASE) + ssku_pkg::VADDR_W'(r_row);
            end
            S_UPDATE: begin
                o_vec_raddr = mac_vaddr;
                o_vec_wr.we = 1'b1;
                if (!r_phase_a) begin
                    // innovation y - c*x
                    o_vec_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::E_BASE)
                                  + ssku_pkg::VADDR_W'(r_row);
                    o_vec_wr.data = i_vec_rdata - res_ext;
                end else begin
                    o_vec_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::N_BASE)
                                  + ssku_pkg::VADDR_W'(r_row);
                    o_vec_wr.data = res_ext;
                end
            end
            S_EMIT_WR: begin
                o_vec_raddr   = mac_vaddr;
                o_vec_wr.we   = 1'b1;
                o_vec_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::X_BASE) + ssku_pkg::VADDR_W'(r_row);
                o_vec_wr.data = i_vec_rdata;
            end
            default: begin
                o_vec_raddr = mac_vaddr;
            end
        endcase
    end

    assign o_mac_ctl.issue = (r_state == S_MAC);
    assign o_mac_ctl.clear = (r_state == S_IDLE) || (r_state == S_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg       <= SEG_X;
            r_phase_a   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_nl        <= '0;
            r_pl        <= '0;
            r_ml        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_nl      <= ssku_pkg::last_index(i_state_count, ssku_pkg::CAP_STATES);
                        r_pl      <= ssku_pkg::last_index({1'b0, i_control_count},
                                                          ssku_pkg::CAP_CONTROLS);
                        r_ml      <= ssku_pkg::last_index({1'b0, i_meas_count},
                                                          ssku_pkg::CAP_MEASUREMENTS);
                        r_phase_a <= 1'b0;
                        r_row     <= '0;
                        r_col     <= '0;
                        r_seg     <= SEG_X;
                        r_state   <= S_MAC;
                    end
                end
                S_MAC: begin
                    priority if (r_seg == SEG_X && r_col == r_nl) begin
                        r_col <= '0;
                        if (r_phase_a) begin
                            r_seg <= SEG_U;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else if (r_seg == SEG_U && r_col == r_pl) begin
                        r_col <= '0;
                        r_seg <= SEG_E;
                    end else if (r_seg == SEG_E && r_col == r_ml) begin
                        r_col   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_mac_busy) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_seg <= SEG_X;
                    r_col <= '0;
                    if (row_end) begin
                        r_row <= '0;
                        if (r_phase_a) begin
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_phase_a <= 1'b1;
                            r_state   <= S_MAC;
                        end
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_EMIT_RD: begin
                    if (slot_free) begin
                        r_state <= S_EMIT_WR;
                    end
                end
                S_EMIT_WR: begin
                    r_out_valid <= 1'b1;
                    r_out_index <= r_row;
                    r_out_value <= i_vec_rdata[ssku_pkg::VALUE_W-1:0];
                    r_out_last  <= (r_row == r_nl);
                    if (r_row == r_nl) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_state_index = r_out_index;
    assign o_state_value = r_out_value;
    assign o_last        = r_out_last;

endmodule

>>> rtl/steady_state_kalman_update.sv
// steady-state kalman update: x = a*x + b*u + k*(y - c*x) in q16.16, one shared mac
// the length of a step is set by the single mac and the one-port vector store
// items are taken only while no step runs; the last result may still wait at the output
// synchronous active-low reset: counts 8/4/4, coefficients, x, u and y read as zero
// uses ssku_pkg, ssku_coef_mem, ssku_vec_mem, ssku_mac, ssku_seq
module steady_state_kalman_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ssku_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssku_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_func,
    input  logic [1:0]                          i_matrix_select,
    input  logic [2:0]                          i_row,
    input  logic [2:0]                          i_column,
    input  logic [31:0]                         i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_state_index,
    output logic [31:0]                         o_state_value,
    output logic                                o_last
);

    logic [3:0]                    r_state_count;
    logic [2:0]                    r_control_count;
    logic [2:0]                    r_meas_count;

    logic                          idle;
    logic                          accept;
    logic                          start;
    ssku_pkg::t_coef_wr            coef_wr;
    ssku_pkg::t_vec_wr             item_wr;
    ssku_pkg::t_vec_wr             eng_wr;
    ssku_pkg::t_vec_wr             vec_wr;
    ssku_pkg::t_mac_ctl            mac_ctl;
    logic [ssku_pkg::CADDR_W-1:0]  coef_raddr;
    logic [ssku_pkg::VALUE_W-1:0]  coef_rdata;
    logic [ssku_pkg::VADDR_W-1:0]  vec_raddr;
    logic [ssku_pkg::OPND_W-1:0]   vec_rdata;
    logic                          mac_busy;
    logic [ssku_pkg::VALUE_W-1:0]  mac_result;
    logic [ssku_pkg::OPND_W-1:0]   value_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count   <= 4'd8;
            r_control_count <= 3'd4;
            r_meas_count    <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssku_pkg::CFG_STATE_COUNT:   r_state_count   <= i_cfg_data;
                ssku_pkg::CFG_CONTROL_COUNT: r_control_count <= i_cfg_data[2:0];
                ssku_pkg::CFG_MEAS_COUNT:    r_meas_count    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = idle;
    assign accept     = i_in_valid && idle;
    assign value_ext  = {i_value[31], i_value};

    always_comb begin
        coef_wr      = '0;
        item_wr      = '0;
        start        = 1'b0;
        coef_wr.addr = {i_matrix_select, i_row, i_column};
        coef_wr.data = i_value;
        item_wr.data = value_ext;
        unique case (ssku_pkg::t_func'(i_func))
            ssku_pkg::FUNC_COEF: begin
                coef_wr.we = accept;
            end
            ssku_pkg::FUNC_CONTROL: begin
                item_wr.we   = accept && (i_column < ssku_pkg::MAX_CONTROLS);
                item_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::U_BASE)
                             + ssku_pkg::VADDR_W'(i_column);
            end
            ssku_pkg::FUNC_MEAS: begin
                item_wr.we   = accept && (i_column < ssku_pkg::MAX_MEASUREMENTS);
                item_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::Y_BASE)
                             + ssku_pkg::VADDR_W'(i_column);
            end
            ssku_pkg::FUNC_PRESET: begin
                item_wr.we   = accept && (i_column < ssku_pkg::MAX_STATES);
                item_wr.addr = ssku_pkg::VADDR_W'(ssku_pkg::X_BASE)
                             + ssku_pkg::VADDR_W'(i_column);
            end
            ssku_pkg::FUNC_STEP: begin
                start = accept;
            end
            default: ;
        endcase
    end

    // item writes only happen while the sequencer is idle
    assign vec_wr = eng_wr.we ? eng_wr : item_wr;

    ssku_coef_mem u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (coef_wr),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    ssku_vec_mem u_vec_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (vec_wr),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    ssku_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_coef   (coef_rdata),
        .i_opnd   (vec_rdata),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    ssku_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_state_count   (r_state_count),
        .i_control_count (r_control_count),
        .i_meas_count    (r_meas_count),
        .i_vec_rdata     (vec_rdata),
        .i_mac_busy      (mac_busy),
        .i_mac_result    (mac_result),
        .i_out_ready     (i_out_ready),
        .o_idle          (idle),
        .o_coef_raddr    (coef_raddr),
        .o_vec_raddr     (vec_raddr),
        .o_vec_wr        (eng_wr),
        .o_mac_ctl       (mac_ctl),
        .o_out_valid     (o_out_valid),
        .o_state_index   (o_state_index),
        .o_state_value   (o_state_value),
        .o_last          (o_last)
    );

endmodule

>>> tb/sv/testbench.sv
// testbench for steady_state_kalman_update: directed and random load and step items,
// bursty sender, stalling receiver, new state checked against an in-bench q16.16 observer
// depends on ssku_pkg and the steady_state_kalman_update rtl
module testbench;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int END_CYCLES      = 250;
    localparam int ITEMS_PER_PHASE = 23;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_PHASE      = 4;
    localparam int SPARE_CFG_PHASE = 3;

    localparam logic [2:0]  FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;
    localparam logic [1:0]  CFG_SPARE     = 2'd3;
    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_HALF        = 32'h0000_8000;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;

    typedef struct {
        logic [2:0]  func;
        logic [1:0]  sel;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } t_load_item;

    typedef struct {
        logic [2:0]  index;
        logic [31:0] value;
        logic        is_last;
    } t_state_elem;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [3:0]  i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic [2:0]  i_func          = '0;
    logic [1:0]  i_matrix_select = '0;
    logic [2:0]  i_row           = '0;
    logic [2:0]  i_column        = '0;
    logic [31:0] i_value         = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_state_index;
    logic [31:0] o_state_value;
    logic        o_last;

    // observer model state
    logic [31:0] coef_mem [ssku_pkg::COEF_DEPTH];
    logic [31:0] x_vec [ssku_pkg::MAX_STATES];
    logic [31:0] u_vec [ssku_pkg::MAX_CONTROLS];
    logic [31:0] y_vec [ssku_pkg::MAX_MEASUREMENTS];
    logic [3:0]  n_cfg = 4'd8;
    logic [2:0]  p_cfg = 3'd4;
    logic [2:0]  m_cfg = 3'd4;

    t_load_item  pending_q [$];
    t_state_elem state_out_q [$];
    t_state_elem want;

    int fail_count   = 0;
    int quiet_cycles = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int seg_left     = 0;
    int rx_mode      = 0;
    int rx_tick      = 0;
    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;

    steady_state_kalman_update DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_matrix_select (i_matrix_select),
        .i_row           (i_row),
        .i_column        (i_column),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_state_index   (o_state_index),
        .o_state_value   (o_state_value),
        .o_last          (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int clamp_count(input logic [3:0] cnt, input int cap);
        if (cnt == 4'd0) return 1;
        if (int'(cnt) > cap) return cap;
        return int'(cnt);
    endfunction

    function automatic logic [31:0] round_to_q16(input logic signed [127:0] acc);
        logic signed [127:0] sh;
        sh = (acc + (128'sd1 <<< (ssku_pkg::FRACTION_BITS - 1))) >>> ssku_pkg::FRACTION_BITS;
        if (sh[127:31] == '0 || sh[127:31] == '1) return sh[31:0];
        return sh[127] ? Q_MIN : Q_MAX;
    endfunction

    function automatic logic signed [31:0] coef_at(input logic [1:0] sel, input int r,
                                                   input int c);
        return coef_mem[{sel, 3'(r), 3'(c)}];
    endfunction

    task automatic apply_item(input t_load_item it);
        logic signed [127:0] acc;
        logic signed [32:0]  innov [ssku_pkg::MAX_MEASUREMENTS];
        logic [31:0]         nxt [ssku_pkg::MAX_STATES];
        t_state_elem         e;
        int                  n, p, m;
        case (it.func)
            ssku_pkg::FUNC_COEF: coef_mem[{it.sel, it.row, it.col}] = it.value;
            ssku_pkg::FUNC_CONTROL:
                if (it.col < ssku_pkg::MAX_CONTROLS) u_vec[it.col] = it.value;
            ssku_pkg::FUNC_MEAS:
                if (it.col < ssku_pkg::MAX_MEASUREMENTS) y_vec[it.col] = it.value;
            ssku_pkg::FUNC_PRESET:
                if (it.col < ssku_pkg::MAX_STATES) x_vec[it.col] = it.value;
            ssku_pkg::FUNC_STEP: begin
                n = clamp_count(n_cfg, ssku_pkg::CAP_STATES);
                p = clamp_count({1'b0, p_cfg}, ssku_pkg::CAP_CONTROLS);
                m = clamp_count({1'b0, m_cfg}, ssku_pkg::CAP_MEASUREMENTS);
                for (int i = 0; i < m; i++) begin
                    acc = '0;
                    for (int j = 0; j < n; j++)
                        acc = acc + coef_at(ssku_pkg::MAT_C, i, j) * $signed(x_vec[j]);
                    innov[i] = $signed(y_vec[i]) - $signed(round_to_q16(acc));
                end
                for (int i = 0; i < n; i++) begin
                    acc = '0;
                    for (int j = 0; j < n; j++)
                        acc = acc + coef_at(ssku_pkg::MAT_A, i, j) * $signed(x_vec[j]);
                    for (int j = 0; j < p; j++)
                        acc = acc + coef_at(ssku_pkg::MAT_B, i, j) * $signed(u_vec[j]);
                    for (int j = 0; j < m; j++)
                        acc = acc + coef_at(ssku_pkg::MAT_K, i, j) * innov[j];
                    nxt[i] = round_to_q16(acc);
                end
                for (int i = 0; i < n; i++) begin
                    x_vec[i]  = nxt[i];
                    e.index   = 3'(i);
                    e.value   = nxt[i];
                    e.is_last = (i + 1 == n);
                    state_out_q.push_back(e);
                end
            end
            default: ;
        endcase
    endtask

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_item(pending_q[0]);
                void'(pending_q.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid      <= 1'b1;
                    i_func          <= pending_q[0].func;
                    i_matrix_select <= pending_q[0].sel;
                    i_row           <= pending_q[0].row;
                    i_column        <= pending_q[0].col;
                    i_value         <= pending_q[0].value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // receiver: segments of stall patterns, plus one long hold on request
    always @(posedge i_clk) begin
        rx_tick++;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 80);
                rx_mode  = $urandom_range(0, 3);
            end
            seg_left--;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= rx_tick[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (state_out_q.size() == 0) begin
                $error("state element with no item pending: index %0d value %h",
                       o_state_index, o_state_value);
                fail_count++;
            end else begin
                want = state_out_q.pop_front();
                if (o_state_index !== want.index) begin
                    $error("state_index: expected %0d, got %0d", want.index, o_state_index);
                    fail_count++;
                end
                if (o_state_value !== want.value) begin
                    $error("state_value: expected %h, got %h", want.value, o_state_value);
                    fail_count++;
                end
                if (o_last !== want.is_last) begin
                    $error("last: expected %0b, got %0b", want.is_last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[steady_state_kalman_update] ERROR");
        $finish;
    end

    task automatic push_item(input logic [2:0] func, input logic [1:0] sel,
                             input logic [2:0] row, input logic [2:0] col,
                             input logic [31:0] value);
        t_load_item it;
        it.func  = func;
        it.sel   = sel;
        it.row   = row;
        it.col   = col;
        it.value = value;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_q16(input logic [31:0] span);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2: v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            3, 4: v = $urandom;
            default: begin
                v = $urandom_range(0, span);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic push_load(input int n, input int p, input int m);
        logic [1:0] sel;
        int         rmax, cmax;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                sel  = 2'($urandom_range(0, 3));
                rmax = (sel == ssku_pkg::MAT_C) ? m : n;
                cmax = (sel == ssku_pkg::MAT_B) ? p : (sel == ssku_pkg::MAT_K) ? m : n;
                if ($urandom_range(0, 4) == 0) begin
                    rmax = 8;
                    cmax = 8;
                end
                push_item(ssku_pkg::FUNC_COEF, sel, 3'($urandom_range(0, rmax - 1)),
                          3'($urandom_range(0, cmax - 1)), rand_q16(32'h0001_4000));
            end
            5: push_item(ssku_pkg::FUNC_CONTROL, 2'($urandom), 3'($urandom),
                         3'($urandom_range(0, p - 1)), rand_q16(32'h0004_0000));
            6, 7: push_item(ssku_pkg::FUNC_MEAS, 2'($urandom), 3'($urandom),
                            3'($urandom_range(0, m - 1)), rand_q16(32'h0004_0000));
            default: push_item(ssku_pkg::FUNC_PRESET, 2'($urandom), 3'($urandom),
                               3'($urandom_range(0, n - 1)), rand_q16(32'h0004_0000));
        endcase
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 2))
            0: push_item(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 2'($urandom),
                         3'($urandom), 3'($urandom), $urandom);
            1: push_item(ssku_pkg::FUNC_CONTROL, 2'($urandom), 3'($urandom),
                         3'($urandom_range(ssku_pkg::MAX_CONTROLS, 7)), $urandom);
            default: push_item(ssku_pkg::FUNC_MEAS, 2'($urandom), 3'($urandom),
                               3'($urandom_range(ssku_pkg::MAX_MEASUREMENTS, 7)), $urandom);
        endcase
    endtask

    task automatic queue_random_phase();
        int counted, n, p, m;
        counted = 0;
        n = clamp_count(n_cfg, ssku_pkg::CAP_STATES);
        p = clamp_count({1'b0, p_cfg}, ssku_pkg::CAP_CONTROLS);
        m = clamp_count({1'b0, m_cfg}, ssku_pkg::CAP_MEASUREMENTS);
        while (counted < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 6) == 0) begin
                push_noise();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_load(n, p, m);
                    counted++;
                end
                push_item(ssku_pkg::FUNC_STEP, 2'($urandom), 3'($urandom), 3'($urandom),
                          $urandom);
                counted++;
                if ($urandom_range(0, 3) == 0) begin
                    push_item(ssku_pkg::FUNC_STEP, 2'($urandom), 3'($urandom), 3'($urandom),
                              $urandom);
                    counted++;
                end
            end
        end
    endtask

    task automatic queue_directed();
        push_item(ssku_pkg::FUNC_STEP, ssku_pkg::MAT_A, 3'd0, 3'd0, 32'h0);
        push_item(ssku_pkg::FUNC_PRESET, ssku_pkg::MAT_A, 3'd0, 3'd0, Q_MAX);
        push_item(ssku_pkg::FUNC_PRESET, ssku_pkg::MAT_A, 3'd0, 3'd7, Q_MIN);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_A, 3'd0, 3'd0, Q_MAX);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_A, 3'd7, 3'd7, Q_MIN);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_A, 3'd1, 3'd0, Q_MIN);
        // half-lsb products round up on both signs
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_A, 3'd4, 3'd4, Q_HALF);
        push_item(ssku_pkg::FUNC_PRESET, ssku_pkg::MAT_A, 3'd0, 3'd4, 32'h0000_0001);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_A, 3'd5, 3'd5, Q_HALF);
        push_item(ssku_pkg::FUNC_PRESET, ssku_pkg::MAT_A, 3'd0, 3'd5, 32'hFFFF_FFFF);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_B, 3'd0, 3'd3, Q_ONE);
        push_item(ssku_pkg::FUNC_CONTROL, ssku_pkg::MAT_A, 3'd0, 3'd3, 32'h0001_8000);
        push_item(ssku_pkg::FUNC_CONTROL, ssku_pkg::MAT_A, 3'd0, 3'd7, Q_MAX);
        // saturated c and extreme y give the widest innovation
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_C, 3'd3, 3'd0, Q_MAX);
        push_item(ssku_pkg::FUNC_MEAS, ssku_pkg::MAT_A, 3'd0, 3'd3, Q_MIN);
        push_item(ssku_pkg::FUNC_MEAS, ssku_pkg::MAT_A, 3'd0, 3'd4, Q_MAX);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_K, 3'd2, 3'd3, Q_ONE);
        push_item(ssku_pkg::FUNC_COEF, ssku_pkg::MAT_K, 3'd7, 3'd7, Q_ONE);
        push_item(FUNC_SPARE_LO, ssku_pkg::MAT_K, 3'd7, 3'd7, Q_MAX);
        push_item(FUNC_SPARE_HI, ssku_pkg::MAT_B, 3'd2, 3'd5, Q_MIN);
        push_item(ssku_pkg::FUNC_STEP, ssku_pkg::MAT_K, 3'd7, 3'd7, 32'hFFFF_FFFF);
        push_item(ssku_pkg::FUNC_STEP, ssku_pkg::MAT_A, 3'd0, 3'd0, 32'h0);
        push_item(ssku_pkg::FUNC_PRESET, ssku_pkg::MAT_A, 3'd0, 3'd7, 32'h0);
        push_item(ssku_pkg::FUNC_STEP, ssku_pkg::MAT_A, 3'd0, 3'd0, 32'h0);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || state_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [3:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            ssku_pkg::CFG_STATE_COUNT: n_cfg = data;
            ssku_pkg::CFG_CONTROL_COUNT: p_cfg = data[2:0];
            ssku_pkg::CFG_MEAS_COUNT: m_cfg = data[2:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // {state count, control count, measurement count} per phase
    function automatic logic [11:0] phase_counts(input int ph);
        case (ph)
            0: return {4'd1, 4'd1, 4'd1};
            1: return {4'd0, 4'd0, 4'd0};
            2: return {4'd15, 4'd12, 4'd7};
            3: return {4'd3, 4'd2, 4'd1};
            4: return {4'd8, 4'd4, 4'd4};
            5: return {4'd5, 4'd3, 4'd2};
            6: return {4'd2, 4'd4, 4'd8};
            default: return 12'($urandom);
        endcase
    endfunction

    initial begin
        logic [11:0] counts;
        foreach (coef_mem[k]) coef_mem[k] = '0;
        foreach (x_vec[k]) x_vec[k] = '0;
        foreach (u_vec[k]) u_vec[k] = '0;
        foreach (y_vec[k]) y_vec[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        wait_idle();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            counts = phase_counts(ph);
            write_cfg(ssku_pkg::CFG_STATE_COUNT, counts[11:8]);
            write_cfg(ssku_pkg::CFG_CONTROL_COUNT, counts[7:4]);
            write_cfg(ssku_pkg::CFG_MEAS_COUNT, counts[3:0]);
            if (ph == SPARE_CFG_PHASE) write_cfg(CFG_SPARE, 4'($urandom));
            if (ph == HOLD_PHASE) hold_req <= ~hold_req;
            queue_random_phase();
            wait_idle();
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && state_out_q.size() == 0) begin
            $display("[steady_state_kalman_update] OK");
        end else begin
            $display("[steady_state_kalman_update] ERROR");
        end
        $finish;
    end

endmodule

>>> steady_state_kalman_update.f
rtl/ssku_pkg.sv
rtl/ssku_coef_mem.sv
rtl/ssku_vec_mem.sv
rtl/ssku_mac.sv
rtl/ssku_seq.sv
rtl/steady_state_kalman_update.sv
tb/sv/testbench.sv
